@@ design/fem_local_matrix_assembly_unit_assert.svh @@
// assertion macros for the local matrix assembly unit
// used by modules that carry concurrent checks; needs no package
`ifndef FEM_LOCAL_MATRIX_ASSEMBLY_UNIT_ASSERT_SVH
`define FEM_LOCAL_MATRIX_ASSEMBLY_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FLA_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FLA_ASSERT(lbl, prop, msg) \
    `FLA_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)
`else
`define FLA_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define FLA_ASSERT(lbl, prop, msg)
`endif
`endif

@@ design/fla_pkg.sv @@
// shared types, register indexes, micro-op table and saturation helpers
// for the local matrix assembly unit; no dependencies
`default_nettype none
package fla_pkg;

    localparam int MAX_BASIS_DEF = 4;
    localparam int CNT_W         = 3;
    localparam int CFG_ADDR_W    = 3;
    localparam int DATA_W        = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_DIFFUSION = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CONV_X    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CONV_Y    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CONV_Z    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_REACTION  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SOURCE    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT    = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_MODE      = 3'd7;

    localparam logic MODE_GALERKIN = 1'b0;

    typedef struct packed {
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic signed [31:0] grad_z;
        logic signed [31:0] basis_value;
        logic               last_basis;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         row;
        logic [2:0]         col;
        logic               is_rhs;
        logic signed [31:0] amount;
        logic               end_of_run;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] diffusion;
        logic signed [31:0] conv_x;
        logic signed [31:0] conv_y;
        logic signed [31:0] conv_z;
        logic signed [31:0] reaction;
        logic signed [31:0] source;
        logic signed [31:0] weight;
        logic               mode;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] gz;
        logic signed [31:0] v;
    } basis_t;

    typedef enum logic [3:0] {
        UOP_GX, UOP_GY, UOP_GZ, UOP_DIFF,
        UOP_CX, UOP_CY, UOP_CZ, UOP_CONV,
        UOP_REAC, UOP_REAC2, UOP_MOUT,
        UOP_RHS_W, UOP_RHS_OUT
    } uop_t;

    typedef enum logic [3:0] {
        A_GXI, A_GYI, A_GZI, A_DIFF, A_CX, A_CY, A_CZ,
        A_REAC, A_WEIGHT, A_TMP, A_ACC_SAT, A_SUM_SAT
    } asel_t;

    typedef enum logic [2:0] {
        B_GXJ, B_GYJ, B_GZJ, B_VI, B_VJ, B_SRC, B_ACC_SAT, B_SUM_SAT
    } bsel_t;

    typedef enum logic [2:0] {
        D_ACC_LOAD, D_ACC_ADD, D_SUM_LOAD, D_SUM_ADD, D_SUM_CONV, D_TMP, D_OUT
    } dest_t;

    typedef struct packed {
        asel_t a_sel;
        bsel_t b_sel;
        dest_t dest;
        logic  last;
    } uop_ctl_t;

    typedef struct packed {
        logic mul_en;
        logic wb_en;
        uop_t uop;
    } mac_ctl_t;

    typedef struct packed {
        logic       wr;
        logic [2:0] row;
        logic [2:0] col;
        logic       is_rhs;
        logic       end_of_run;
    } out_tag_t;

    function automatic uop_ctl_t uop_decode(uop_t u);
        uop_ctl_t c;
        c.a_sel = A_GXI;
        c.b_sel = B_GXJ;
        c.dest  = D_ACC_LOAD;
        c.last  = 1'b0;
        case (u)
            UOP_GX: begin
                c.a_sel = A_GXI;     c.b_sel = B_GXJ;     c.dest = D_ACC_LOAD;
            end
            UOP_GY: begin
                c.a_sel = A_GYI;     c.b_sel = B_GYJ;     c.dest = D_ACC_ADD;
            end
            UOP_GZ: begin
                c.a_sel = A_GZI;     c.b_sel = B_GZJ;     c.dest = D_ACC_ADD;
            end
            UOP_DIFF: begin
                c.a_sel = A_DIFF;    c.b_sel = B_ACC_SAT; c.dest = D_SUM_LOAD;
            end
            UOP_CX: begin
                c.a_sel = A_CX;      c.b_sel = B_GXJ;     c.dest = D_ACC_LOAD;
            end
            UOP_CY: begin
                c.a_sel = A_CY;      c.b_sel = B_GYJ;     c.dest = D_ACC_ADD;
            end
            UOP_CZ: begin
                c.a_sel = A_CZ;      c.b_sel = B_GZJ;     c.dest = D_ACC_ADD;
            end
            UOP_CONV: begin
                c.a_sel = A_ACC_SAT; c.b_sel = B_VI;      c.dest = D_SUM_CONV;
            end
            UOP_REAC: begin
                c.a_sel = A_REAC;    c.b_sel = B_VJ;      c.dest = D_TMP;
            end
            UOP_REAC2: begin
                c.a_sel = A_TMP;     c.b_sel = B_VI;      c.dest = D_SUM_ADD;
            end
            UOP_MOUT: begin
                c.a_sel = A_WEIGHT;  c.b_sel = B_SUM_SAT; c.dest = D_OUT;
                c.last  = 1'b1;
            end
            UOP_RHS_W: begin
                c.a_sel = A_WEIGHT;  c.b_sel = B_VI;      c.dest = D_TMP;
            end
            UOP_RHS_OUT: begin
                c.a_sel = A_TMP;     c.b_sel = B_SRC;     c.dest = D_OUT;
                c.last  = 1'b1;
            end
            default: begin
                c.last = 1'b1;
            end
        endcase
        return c;
    endfunction

    function automatic logic signed [31:0] sat48(logic signed [47:0] x);
        logic signed [31:0] r;
        if (x[47:31] == {17{x[47]}}) begin
            r = x[31:0];
        end else begin
            r = x[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat34(logic signed [33:0] x);
        logic signed [31:0] r;
        if (x[33:31] == {3{x[33]}}) begin
            r = x[31:0];
        end else begin
            r = x[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ design/fla_basis_mem.sv @@
// basis function store: one write port, two registered read ports
// depends on fla_pkg for the row type
`default_nettype none
module fla_basis_mem #(
    parameter int DEPTH = fla_pkg::MAX_BASIS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic            aclk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire fla_pkg::basis_t wdata,
    input  wire logic [AW-1:0]   raddr_a,
    input  wire logic [AW-1:0]   raddr_b,
    output fla_pkg::basis_t      rdata_a,
    output fla_pkg::basis_t      rdata_b
);
    import fla_pkg::*;

    basis_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

@@ design/fla_mac_unit.sv @@
// shared q16.16 multiply, floor, saturate and accumulate unit
// operands picked by the micro-op table in fla_pkg
`default_nettype none
module fla_mac_unit (
    input  wire logic              aclk,
    input  wire fla_pkg::mac_ctl_t ctl,
    input  wire fla_pkg::cfg_t     cfg,
    input  wire fla_pkg::basis_t   row_i,
    input  wire fla_pkg::basis_t   row_j,
    output logic signed [31:0]     q_out
);
    import fla_pkg::*;

    uop_ctl_t           dec;
    logic signed [31:0] a_op;
    logic signed [31:0] b_op;
    logic signed [63:0] prod_next;
    logic signed [63:0] prod_reg;
    logic signed [33:0] acc_reg;
    logic signed [33:0] sum_reg;
    logic signed [31:0] tmp_reg;
    logic signed [31:0] acc_sat;
    logic signed [31:0] sum_sat;
    logic signed [31:0] q;
    logic signed [33:0] q_ext;

    assign dec     = uop_decode(ctl.uop);
    assign acc_sat = sat34(acc_reg);
    assign sum_sat = sat34(sum_reg);
    assign q       = sat48(prod_reg[63:16]);
    assign q_ext   = {{2{q[31]}}, q};
    assign q_out   = q;

    always_comb begin
        case (dec.a_sel)
            A_GXI:     a_op = row_i.gx;
            A_GYI:     a_op = row_i.gy;
            A_GZI:     a_op = row_i.gz;
            A_DIFF:    a_op = cfg.diffusion;
            A_CX:      a_op = cfg.conv_x;
            A_CY:      a_op = cfg.conv_y;
            A_CZ:      a_op = cfg.conv_z;
            A_REAC:    a_op = cfg.reaction;
            A_WEIGHT:  a_op = cfg.weight;
            A_TMP:     a_op = tmp_reg;
            A_ACC_SAT: a_op = acc_sat;
            A_SUM_SAT: a_op = sum_sat;
            default:   a_op = cfg.weight;
        endcase
    end

    always_comb begin
        case (dec.b_sel)
            B_GXJ:     b_op = row_j.gx;
            B_GYJ:     b_op = row_j.gy;
            B_GZJ:     b_op = row_j.gz;
            B_VI:      b_op = row_i.v;
            B_VJ:      b_op = row_j.v;
            B_SRC:     b_op = cfg.source;
            B_ACC_SAT: b_op = acc_sat;
            B_SUM_SAT: b_op = sum_sat;
            default:   b_op = row_i.v;
        endcase
    end

    assign prod_next = a_op * b_op;

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= prod_next;
        end
        if (ctl.wb_en) begin
            case (dec.dest)
                D_ACC_LOAD: acc_reg <= q_ext;
                D_ACC_ADD:  acc_reg <= acc_reg + q_ext;
                D_SUM_LOAD: sum_reg <= q_ext;
                D_SUM_ADD:  sum_reg <= sum_reg + q_ext;
                D_SUM_CONV: begin
                    if (cfg.mode == MODE_GALERKIN) begin
                        sum_reg <= sum_reg + q_ext;
                    end
                end
                D_TMP:      tmp_reg <= q;
                D_OUT:      tmp_reg <= tmp_reg;
                default:    tmp_reg <= tmp_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ design/fla_seq.sv @@
// sequencer: load counting, row/column walk and micro-op stepping
// depends on fla_pkg and the assertion macro header
`default_nettype none
`include "fem_local_matrix_assembly_unit_assert.svh"
module fla_seq #(
    parameter int MAX_BASIS = fla_pkg::MAX_BASIS_DEF,
    localparam int AW       = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire logic          s_last,
    output logic               s_ready,
    input  wire logic          out_free,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output logic [AW-1:0]      rd_i,
    output logic [AW-1:0]      rd_j,
    output fla_pkg::mac_ctl_t  mac_ctl,
    output fla_pkg::out_tag_t  out_tag
);
    import fla_pkg::*;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_MUL   = 4'b0100,
        ST_WB    = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [AW-1:0]    i_reg, i_next;
    logic [AW-1:0]    j_reg, j_next;
    logic             rhs_reg, rhs_next;
    uop_t             uop_reg, uop_next;
    uop_ctl_t         ctl;
    logic             accept;
    logic             room;
    logic [CNT_W-1:0] count_inc;
    logic             i_last;
    logic             j_last;
    logic             wb_go;

    assign ctl       = uop_decode(uop_reg);
    assign s_ready   = (state_reg == ST_LOAD);
    assign accept    = s_valid && s_ready;
    assign room      = (count_reg < CNT_W'(MAX_BASIS));
    assign count_inc = count_reg + 3'd1;
    assign i_last    = (CNT_W'(i_reg) == n_reg - 3'd1);
    assign j_last    = (CNT_W'(j_reg) == n_reg - 3'd1);
    assign wb_go     = (state_reg == ST_WB) && ((ctl.dest != D_OUT) || out_free);

    assign mem_we    = accept && room;
    assign mem_waddr = count_reg[AW-1:0];
    assign rd_i      = i_reg;
    assign rd_j      = j_reg;

    assign mac_ctl.mul_en = (state_reg == ST_MUL);
    assign mac_ctl.wb_en  = wb_go;
    assign mac_ctl.uop    = uop_reg;

    assign out_tag.wr         = wb_go && (ctl.dest == D_OUT);
    assign out_tag.row        = 3'(i_reg);
    assign out_tag.col        = rhs_reg ? 3'd0 : 3'(j_reg);
    assign out_tag.is_rhs     = rhs_reg;
    assign out_tag.end_of_run = !rhs_reg && i_last && j_last;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        rhs_next   = rhs_reg;
        uop_next   = uop_reg;
        case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (room) begin
                        count_next = count_inc;
                    end
                    if (s_last) begin
                        n_next     = room ? count_inc : count_reg;
                        i_next     = '0;
                        j_next     = '0;
                        rhs_next   = 1'b1;
                        uop_next   = UOP_RHS_W;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_WB;
            end
            ST_WB: begin
                if (wb_go) begin
                    if (!ctl.last) begin
                        uop_next   = uop_t'(uop_reg + 4'd1);
                        state_next = ST_MUL;
                    end else if (rhs_reg) begin
                        state_next = ST_FETCH;
                        if (i_last) begin
                            rhs_next = 1'b0;
                            i_next   = '0;
                            j_next   = '0;
                            uop_next = UOP_GX;
                        end else begin
                            i_next   = i_reg + 1'b1;
                            uop_next = UOP_RHS_W;
                        end
                    end else begin
                        uop_next = UOP_GX;
                        if (j_last) begin
                            if (i_last) begin
                                count_next = '0;
                                state_next = ST_LOAD;
                            end else begin
                                i_next     = i_reg + 1'b1;
                                j_next     = '0;
                                state_next = ST_FETCH;
                            end
                        end else begin
                            j_next     = j_reg + 1'b1;
                            state_next = ST_FETCH;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            rhs_reg   <= 1'b0;
            uop_reg   <= UOP_GX;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            rhs_reg   <= rhs_next;
            uop_reg   <= uop_next;
        end
    end

    `FLA_ASSERT(a_count_bound, (count_reg <= CNT_W'(MAX_BASIS)), "load count past store depth")
    `FLA_ASSERT(a_row_in_run, ((state_reg != ST_LOAD) |-> (CNT_W'(i_reg) < n_reg)), "row index out of run")
    `FLA_ASSERT(a_col_in_run, ((state_reg != ST_LOAD) |-> (CNT_W'(j_reg) < n_reg)), "col index out of run")
    `FLA_ASSERT(a_end_idle, ((out_tag.wr && out_tag.end_of_run) |=> (s_ready && (count_reg == '0))), "run end did not return to load")

endmodule
`default_nettype wire

@@ design/fem_local_matrix_assembly_unit.sv @@
// top level of the local matrix assembly unit: config registers, output register
// depends on fla_pkg, fla_basis_mem, fla_mac_unit and fla_seq
//
//   port group  dir  handshake          content
//   s_*         in   s_valid/s_ready    one basis function per request
//   m_*         out  m_valid/m_ready    one rhs or matrix increment per request
//   cfg_*       in   cfg_wr_en          register write, no wait
//
// loading: one cycle per request while the sequencer is idle
// emission: each rhs row and each matrix entry is a sequence of micro-ops, all through one
//   multiplier (product register, then floor/saturate/accumulate writeback)
// a full output register with m_ready low stalls the sequencer at the next output writeback
// reset is synchronous, active low; the store itself is not cleared
`default_nettype none
module fem_local_matrix_assembly_unit #(
    parameter int MAX_BASIS = fla_pkg::MAX_BASIS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire fla_pkg::in_item_t             s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output fla_pkg::out_item_t                 m_data,
    input  wire logic                          cfg_wr_en,
    input  wire logic [fla_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [fla_pkg::DATA_W-1:0]    cfg_wr_data
);
    import fla_pkg::*;

    localparam int AW = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;

    cfg_t               cfg_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;
    logic               out_free;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      rd_i;
    logic [AW-1:0]      rd_j;
    basis_t             wr_row;
    basis_t             row_i;
    basis_t             row_j;
    mac_ctl_t           mac_ctl;
    out_tag_t           out_tag;
    logic signed [31:0] q;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign wr_row.gx = s_data.grad_x;
    assign wr_row.gy = s_data.grad_y;
    assign wr_row.gz = s_data.grad_z;
    assign wr_row.v  = s_data.basis_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DIFFUSION: cfg_reg.diffusion <= cfg_wr_data;
                REG_CONV_X:    cfg_reg.conv_x    <= cfg_wr_data;
                REG_CONV_Y:    cfg_reg.conv_y    <= cfg_wr_data;
                REG_CONV_Z:    cfg_reg.conv_z    <= cfg_wr_data;
                REG_REACTION:  cfg_reg.reaction  <= cfg_wr_data;
                REG_SOURCE:    cfg_reg.source    <= cfg_wr_data;
                REG_WEIGHT:    cfg_reg.weight    <= cfg_wr_data;
                REG_MODE:      cfg_reg.mode      <= cfg_wr_data[0];
                default:       cfg_reg.mode      <= cfg_reg.mode;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_tag.wr) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_tag.wr) begin
            m_data_reg.row        <= out_tag.row;
            m_data_reg.col        <= out_tag.col;
            m_data_reg.is_rhs     <= out_tag.is_rhs;
            m_data_reg.amount     <= q;
            m_data_reg.end_of_run <= out_tag.end_of_run;
        end
    end

    fla_seq #(
        .MAX_BASIS (MAX_BASIS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_last    (s_data.last_basis),
        .s_ready   (s_ready),
        .out_free  (out_free),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .rd_i      (rd_i),
        .rd_j      (rd_j),
        .mac_ctl   (mac_ctl),
        .out_tag   (out_tag)
    );

    fla_basis_mem #(
        .DEPTH (MAX_BASIS)
    ) u_mem (
        .aclk    (aclk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (wr_row),
        .raddr_a (rd_i),
        .raddr_b (rd_j),
        .rdata_a (row_i),
        .rdata_b (row_j)
    );

    fla_mac_unit u_mac (
        .aclk  (aclk),
        .ctl   (mac_ctl),
        .cfg   (cfg_reg),
        .row_i (row_i),
        .row_j (row_j),
        .q_out (q)
    );

endmodule
`default_nettype wire
